/* rtl/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the bitmap block allocator: request and
// result structs, status codes, and the command passed from front to back.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int NUM_BLOCKS_DEF      = 64;
  localparam int BYTES_PER_BLOCK_DEF = 8;
  localparam int MAX_RESULTS         = 64;

  localparam int SIZE_W = 10;
  localparam int BLK_W  = 6;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_ALLOC = 2'd0;
  localparam logic [1:0] ST_FREED = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  typedef struct packed {
    logic              opcode;
    logic [SIZE_W-1:0] size_bytes;
    logic [BLK_W-1:0]  free_block;
  } in_req_t;

  typedef struct packed {
    logic [BLK_W-1:0] block_number;
    logic [1:0]       status;
    logic             last;
  } out_res_t;

  typedef enum logic [1:0] {
    CMD_ALLOC,
    CMD_FREE,
    CMD_BAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [SIZE_W-1:0] size;
    logic [BLK_W-1:0]  blk;
  } cmd_t;

  // Queue status seen by front and back.
  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

endpackage

/* rtl/bba_front.sv */
// ----------------------------------------------------------------------------
// bba_front
// Accepts requests and classifies them: frees pass on, allocations of a
// zero or oversized byte count become bad commands.
// ----------------------------------------------------------------------------
module bba_front #(
  parameter int NUM_BLOCKS      = bba_pkg::NUM_BLOCKS_DEF,
  parameter int BYTES_PER_BLOCK = bba_pkg::BYTES_PER_BLOCK_DEF
) (
  input  logic             in_valid,
  output logic             in_stall,
  input  bba_pkg::in_req_t in_req,
  input  bba_pkg::q_stat_t q_stat,
  output logic             push,
  output bba_pkg::cmd_t    push_cmd
);

  localparam int LIM_BLK   = (NUM_BLOCKS < bba_pkg::MAX_RESULTS) ?
                             NUM_BLOCKS : bba_pkg::MAX_RESULTS;
  localparam int LIM_BYTES = LIM_BLK * BYTES_PER_BLOCK;

  logic size_bad;

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  // Rounded block count exceeds the limit exactly when bytes exceed limit*block.
  assign size_bad = (in_req.size_bytes == '0) ||
                    (32'(in_req.size_bytes) > 32'(LIM_BYTES));

  always_comb begin
    push_cmd.size = in_req.size_bytes;
    push_cmd.blk  = in_req.free_block;
    if (in_req.opcode == bba_pkg::OP_FREE) begin
      push_cmd.kind = bba_pkg::CMD_FREE;
    end else if (size_bad) begin
      push_cmd.kind = bba_pkg::CMD_BAD;
    end else begin
      push_cmd.kind = bba_pkg::CMD_ALLOC;
    end
  end

endmodule

/* rtl/bba_queue.sv */
// ----------------------------------------------------------------------------
// bba_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module bba_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  bba_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output bba_pkg::cmd_t    head,
  output bba_pkg::q_stat_t q_stat
);

  bba_pkg::cmd_t mem_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;

  assign head            = mem_r[rd_ptr_r];
  assign q_stat.full     = (cnt_r == 2'd2);
  assign q_stat.nonempty = (cnt_r != 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

/* rtl/bba_back.sv */
// ----------------------------------------------------------------------------
// bba_back
// Executes commands against the used-block bitmap and drives the result
// register. Allocation hands out one lowest free block per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module bba_back #(
  parameter int NUM_BLOCKS      = bba_pkg::NUM_BLOCKS_DEF,
  parameter int BYTES_PER_BLOCK = bba_pkg::BYTES_PER_BLOCK_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bba_pkg::cmd_t     head,
  input  bba_pkg::q_stat_t  q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output bba_pkg::out_res_t out_res
);

  localparam int IW  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int NG  = (NUM_BLOCKS + 7) / 8;
  localparam int GW  = (NG > 1) ? $clog2(NG) : 1;
  localparam int PADW = NG * 8;

  typedef enum logic {
    S_IDLE,
    S_ALLOC
  } state_t;

  state_t                       state_r;
  logic [NUM_BLOCKS-1:0]        used_r;
  logic [bba_pkg::SIZE_W-1:0]   bytes_r;
  logic                         out_valid_r;
  bba_pkg::out_res_t            out_r;

  logic [PADW-1:0] map_pad;
  logic [NG-1:0]   grp_free;
  logic [GW-1:0]   g_sel;
  logic [7:0]      word;
  logic [2:0]      b_sel;
  logic            any_free;
  logic [IW-1:0]   ff_idx;
  logic [IW-1:0]   f_idx;
  logic            f_ok;
  logic            can_emit;
  logic            run_last;
  logic            res_load;

  // Two-level first-free search: group summary, then bit within the group.
  always_comb begin
    map_pad = '1;
    map_pad[NUM_BLOCKS-1:0] = used_r;
    for (int g = 0; g < NG; g++) begin
      grp_free[g] = ~&map_pad[g*8 +: 8];
    end
    g_sel = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_free[g]) begin
        g_sel = GW'(g);
      end
    end
    word  = map_pad[32'(g_sel)*8 +: 8];
    b_sel = '0;
    for (int b = 7; b >= 0; b--) begin
      if (!word[b]) begin
        b_sel = 3'(b);
      end
    end
  end

  assign any_free = |grp_free;
  assign ff_idx   = IW'({g_sel, b_sel});
  assign f_idx    = IW'(head.blk);
  assign f_ok     = (32'(head.blk) < 32'(NUM_BLOCKS)) && used_r[f_idx];
  assign can_emit = !out_valid_r || !out_stall;
  assign run_last = (32'(bytes_r) <= 32'(BYTES_PER_BLOCK));
  assign pop      = (state_r == S_IDLE) && q_stat.nonempty && can_emit;

  // Load the result register on a free or bad request, or on each allocate step.
  assign res_load = pop ? (head.kind != bba_pkg::CMD_ALLOC)
                        : ((state_r == S_ALLOC) && can_emit);

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      bytes_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (pop) begin
            unique case (head.kind)
              bba_pkg::CMD_ALLOC: begin
                bytes_r <= head.size;
                state_r <= S_ALLOC;
              end
              bba_pkg::CMD_FREE: begin
                out_r.last  <= 1'b1;
                if (f_ok) begin
                  used_r[f_idx]      <= 1'b0;
                  out_r.block_number <= head.blk;
                  out_r.status       <= bba_pkg::ST_FREED;
                end else begin
                  out_r.block_number <= '0;
                  out_r.status       <= bba_pkg::ST_BAD;
                end
              end
              default: begin
                out_r.last         <= 1'b1;
                out_r.block_number <= '0;
                out_r.status       <= bba_pkg::ST_BAD;
              end
            endcase
          end
        end
        S_ALLOC: begin
          if (can_emit) begin
            if (!any_free) begin
              out_r.block_number <= '0;
              out_r.status       <= bba_pkg::ST_FULL;
              out_r.last         <= 1'b1;
              state_r            <= S_IDLE;
            end else begin
              used_r[ff_idx]     <= 1'b1;
              out_r.block_number <= bba_pkg::BLK_W'(ff_idx);
              out_r.status       <= bba_pkg::ST_ALLOC;
              out_r.last         <= run_last;
              if (run_last) begin
                state_r <= S_IDLE;
              end else begin
                bytes_r <= bytes_r - bba_pkg::SIZE_W'(BYTES_PER_BLOCK);
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/bitmap_block_allocator_unit.sv */
// ----------------------------------------------------------------------------
// bitmap_block_allocator_unit
// First-fit block allocator over a used-block bitmap: allocate runs, free one.
// ----------------------------------------------------------------------------
// Flow: each accepted request is written into the command queue; the back end pops
//   it and registers its result, and an allocate first enters S_ALLOC.
// Allocate emits one block id per cycle from the first-free search, unless the output
//   stalls; the queue keeps taking requests while an allocate runs, until it is full.
// Reset (synchronous): bitmap clears to all free and the command queue empties.
module bitmap_block_allocator_unit #(
  parameter int NUM_BLOCKS      = bba_pkg::NUM_BLOCKS_DEF,
  parameter int BYTES_PER_BLOCK = bba_pkg::BYTES_PER_BLOCK_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bba_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output bba_pkg::out_res_t out_res
);

  logic             q_push;
  logic             q_pop;
  bba_pkg::cmd_t    push_cmd;
  bba_pkg::cmd_t    q_head;
  bba_pkg::q_stat_t q_stat;

  bba_front #(
    .NUM_BLOCKS      (NUM_BLOCKS),
    .BYTES_PER_BLOCK (BYTES_PER_BLOCK)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .q_stat   (q_stat),
    .push     (q_push),
    .push_cmd (push_cmd)
  );

  bba_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .q_stat   (q_stat)
  );

  bba_back #(
    .NUM_BLOCKS      (NUM_BLOCKS),
    .BYTES_PER_BLOCK (BYTES_PER_BLOCK)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_stat    (q_stat),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_stat.nonempty)
    else $error("command queue underflow");

  a_err_zero_blk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_res.status == bba_pkg::ST_FULL ||
                  out_res.status == bba_pkg::ST_BAD) |-> out_res.block_number == '0)
    else $error("error result carries a block number");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.status != bba_pkg::ST_ALLOC |-> out_res.last)
    else $error("free or error result not marked last");

endmodule

/* tb/sv/tb_bitmap_block_allocator_unit.sv */
// ----------------------------------------------------------------------------
// tb_bitmap_block_allocator_unit
// Self-checking bench for the first-fit block allocator. A directed table
// exercises zero and oversized requests, double frees, and the disk filling
// both at the start and part-way through a run. Random requests follow, mostly
// frees of blocks in use mixed with allocates. Expected results come from the
// table or from a bitmap predictor in the bench, and each one is compared with
// the result stream. The sender and the receiver idle at random in the first two
// of three phases, and the run ends with a final drain.
// ----------------------------------------------------------------------------
module tb_bitmap_block_allocator_unit;

  localparam int NBLK           = bba_pkg::NUM_BLOCKS_DEF;
  localparam int BPB            = bba_pkg::BYTES_PER_BLOCK_DEF;
  localparam int RAND_PER_PHASE = 70;
  localparam int IDLE_LIMIT     = 4000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;
  localparam int SRC_PCT  [3]   = '{11, 54, 0};
  localparam int SINK_PCT [3]   = '{54, 11, 0};
  localparam bba_pkg::out_res_t NO_RES = '0;

  typedef struct {
    bba_pkg::in_req_t  req;
    bit                typed;
    bba_pkg::out_res_t res;
  } dir_row_t;

  // Rows with typed set carry their one expected result; the rest use the predictor.
  dir_row_t dir_rows [20] = '{
    '{'{bba_pkg::OP_ALLOC, 10'd0,   6'd0},  1'b1, '{6'd0,  bba_pkg::ST_BAD,   1'b1}},
    '{'{bba_pkg::OP_FREE,  10'd0,   6'd5},  1'b1, '{6'd0,  bba_pkg::ST_BAD,   1'b1}},
    '{'{bba_pkg::OP_ALLOC, 10'd1,   6'd0},  1'b1, '{6'd0,  bba_pkg::ST_ALLOC, 1'b1}},
    '{'{bba_pkg::OP_ALLOC, 10'd8,   6'd0},  1'b1, '{6'd1,  bba_pkg::ST_ALLOC, 1'b1}},
    '{'{bba_pkg::OP_ALLOC, 10'd9,   6'd0},  1'b0, NO_RES},
    '{'{bba_pkg::OP_FREE,  10'd0,   6'd0},  1'b1, '{6'd0,  bba_pkg::ST_FREED, 1'b1}},
    '{'{bba_pkg::OP_FREE,  10'd0,   6'd0},  1'b1, '{6'd0,  bba_pkg::ST_BAD,   1'b1}},
    '{'{bba_pkg::OP_ALLOC, 10'd520, 6'd0},  1'b1, '{6'd0,  bba_pkg::ST_BAD,   1'b1}},
    '{'{bba_pkg::OP_ALLOC, 10'h3FF, 6'd0},  1'b1, '{6'd0,  bba_pkg::ST_BAD,   1'b1}},
    '{'{bba_pkg::OP_ALLOC, 10'd17,  6'd63}, 1'b0, NO_RES},
    '{'{bba_pkg::OP_FREE,  10'd0,   6'd3},  1'b1, '{6'd3,  bba_pkg::ST_FREED, 1'b1}},
    '{'{bba_pkg::OP_ALLOC, 10'd512, 6'd0},  1'b0, NO_RES},
    '{'{bba_pkg::OP_ALLOC, 10'd8,   6'd0},  1'b1, '{6'd0,  bba_pkg::ST_FULL,  1'b1}},
    '{'{bba_pkg::OP_FREE,  10'd0,   6'd63}, 1'b1, '{6'd63, bba_pkg::ST_FREED, 1'b1}},
    '{'{bba_pkg::OP_FREE,  10'd0,   6'd32}, 1'b1, '{6'd32, bba_pkg::ST_FREED, 1'b1}},
    '{'{bba_pkg::OP_ALLOC, 10'd24,  6'd0},  1'b0, NO_RES},
    '{'{bba_pkg::OP_FREE,  10'h3FF, 6'd62}, 1'b1, '{6'd62, bba_pkg::ST_FREED, 1'b1}},
    '{'{bba_pkg::OP_ALLOC, 10'd505, 6'd0},  1'b0, NO_RES},
    '{'{bba_pkg::OP_FREE,  10'd0,   6'd0},  1'b1, '{6'd0,  bba_pkg::ST_FREED, 1'b1}},
    '{'{bba_pkg::OP_ALLOC, 10'd504, 6'd0},  1'b0, NO_RES}
  };

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  bba_pkg::in_req_t  in_req;
  logic              out_valid;
  logic              out_stall;
  bba_pkg::out_res_t out_res;

  logic [NBLK-1:0]   blk_used;
  bba_pkg::out_res_t step_res [$];
  bba_pkg::out_res_t expected_res [$];
  int                src_idle_pct;
  int                sink_stall_pct;
  int                mismatch_cnt;
  int                idle_cycles;

  bitmap_block_allocator_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  always #5 clk = ~clk;

  function automatic bba_pkg::out_res_t make_res(logic [bba_pkg::BLK_W-1:0] blk,
                                                 logic [1:0] st, logic lst);
    bba_pkg::out_res_t r;
    r.block_number = blk;
    r.status       = st;
    r.last         = lst;
    return r;
  endfunction

  // First-fit allocator over the bench's own bitmap; fills step_res.
  function automatic void predict_request(bba_pkg::in_req_t r);
    int unsigned need;
    int          hit;
    step_res.delete();
    if (r.opcode == bba_pkg::OP_FREE) begin
      if (r.free_block < NBLK && blk_used[r.free_block]) begin
        blk_used[r.free_block] = 1'b0;
        step_res.push_back(make_res(r.free_block, bba_pkg::ST_FREED, 1'b1));
      end else begin
        step_res.push_back(make_res('0, bba_pkg::ST_BAD, 1'b1));
      end
      return;
    end
    need = (int'(r.size_bytes) + BPB - 1) / BPB;
    if (r.size_bytes == '0 || need > NBLK || need > bba_pkg::MAX_RESULTS) begin
      step_res.push_back(make_res('0, bba_pkg::ST_BAD, 1'b1));
      return;
    end
    for (int k = 0; k < need; k++) begin
      hit = -1;
      for (int i = NBLK - 1; i >= 0; i--)
        if (!blk_used[i]) hit = i;
      if (hit < 0) begin
        step_res.push_back(make_res('0, bba_pkg::ST_FULL, 1'b1));
        return;
      end
      blk_used[hit] = 1'b1;
      step_res.push_back(make_res(hit[bba_pkg::BLK_W-1:0], bba_pkg::ST_ALLOC,
                                  k == need - 1));
    end
  endfunction

  // Hold the request until the block takes it, with random idle cycles first.
  task automatic drive_request(bba_pkg::in_req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic void note_failure(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endfunction

  always @(posedge clk) begin : result_check
    bba_pkg::out_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_res.size() == 0) begin
        note_failure($sformatf("unexpected result blk %0d status %0d last %0d",
                               out_res.block_number, out_res.status, out_res.last));
      end else begin
        want = expected_res.pop_front();
        if (out_res.block_number !== want.block_number ||
            out_res.status !== want.status || out_res.last !== want.last)
          note_failure($sformatf(
            "expected blk %0d status %0d last %0d, got blk %0d status %0d last %0d",
            want.block_number, want.status, want.last,
            out_res.block_number, out_res.status, out_res.last));
      end
    end
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    bba_pkg::in_req_t req;
    int               pick;
    int               idx;
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req         = '0;
    out_stall      = 1'b0;
    blk_used       = '0;
    src_idle_pct   = SRC_PCT[0];
    sink_stall_pct = SINK_PCT[0];
    mismatch_cnt   = 0;
    idle_cycles    = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct   = SRC_PCT[ph];
      sink_stall_pct = SINK_PCT[ph];
      if (ph == 0) begin
        foreach (dir_rows[i]) begin
          drive_request(dir_rows[i].req);
          predict_request(dir_rows[i].req);
          if (dir_rows[i].typed)
            expected_res.push_back(dir_rows[i].res);
          else
            foreach (step_res[k]) expected_res.push_back(step_res[k]);
        end
      end
      repeat (RAND_PER_PHASE) begin
        pick           = $urandom_range(99);
        req.opcode     = (pick < 60) ? bba_pkg::OP_FREE : bba_pkg::OP_ALLOC;
        req.size_bytes = bba_pkg::SIZE_W'($urandom_range(1023));
        req.free_block = bba_pkg::BLK_W'($urandom);
        if (pick < 55 && blk_used != '0) begin
          // pick a block that is actually in use
          do idx = $urandom_range(NBLK - 1); while (!blk_used[idx]);
          req.free_block = bba_pkg::BLK_W'(idx);
        end else if (pick >= 60) begin
          if (pick < 88)
            req.size_bytes = bba_pkg::SIZE_W'($urandom_range(24, 1));
          else if (pick < 92)
            req.size_bytes = bba_pkg::SIZE_W'($urandom_range(512, 25));
          else if (pick < 96)
            req.size_bytes = '0;
          else
            req.size_bytes = bba_pkg::SIZE_W'($urandom_range(1023, 513));
        end
        drive_request(req);
        predict_request(req);
        foreach (step_res[k]) expected_res.push_back(step_res[k]);
      end
    end
    in_valid <= 1'b0;

    while (expected_res.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
